[design/bts_pkg.sv]
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and constants for the bitmap texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

	localparam int TEX_W_MAX_DEF = 64;
	localparam int TEX_H_MAX_DEF = 64;
	localparam int MAX_SPAN_DEF  = 64;

	localparam int DIM_W  = 16;
	localparam int PADDR_W = 5;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_SPAN  = 1'b1;

	localparam logic [1:0] TILE_CLAMP  = 2'd0;
	localparam logic [1:0] TILE_REPEAT = 2'd1;
	localparam logic [1:0] TILE_MIRROR = 2'd2;

	localparam logic [2:0] REG_MAT_A = 3'd0;
	localparam logic [2:0] REG_MAT_B = 3'd1;
	localparam logic [2:0] REG_MAT_C = 3'd2;
	localparam logic [2:0] REG_MAT_D = 3'd3;
	localparam logic [2:0] REG_MAT_E = 3'd4;
	localparam logic [2:0] REG_MAT_F = 3'd5;
	localparam logic [2:0] REG_DIMS  = 3'd6;
	localparam logic [2:0] REG_TILE  = 3'd7;

	typedef struct packed {
		logic        func;
		logic [11:0] dest_x;
		logic [11:0] dest_y;
		logic [6:0]  span_count;
		logic [11:0] texel_index;
		logic [31:0] texel_value;
	} in_item_t;

	typedef struct packed {
		logic [31:0] texel_out;
		logic        span_last;
	} out_item_t;

endpackage

[design/bts_texmem.sv]
// ----------------------------------------------------------------------------
// bts_texmem
// Single write port, single registered read port texel memory.
// ----------------------------------------------------------------------------
module bts_texmem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	logic [31:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[design/bts_modunit.sv]
// ----------------------------------------------------------------------------
// bts_modunit
// Iterative remainder unit, four quotient bits per cycle over a 32-bit value.
// ----------------------------------------------------------------------------
module bts_modunit #(
	parameter int MOD_W = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [31:0]      value,
	input  logic [MOD_W-1:0] modulus,
	output logic             done,
	output logic [MOD_W-1:0] rem
);
	logic [31:0]      dvd_q;
	logic [MOD_W-1:0] rem_q;
	logic [MOD_W-1:0] mod_q;
	logic [2:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [MOD_W-1:0] rem_nxt;

	always_comb begin
		logic [MOD_W:0] t;
		rem_nxt = rem_q;
		for (int i = 0; i < 4; i++) begin
			t = {rem_nxt, dvd_q[31-i]};
			if (t >= {1'b0, mod_q}) begin
				t = t - {1'b0, mod_q};
			end
			rem_nxt = t[MOD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= value;
			rem_q <= '0;
			mod_q <= modulus;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[27:0], 4'b0};
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

[design/bitmap_texture_sampler_top.sv]
// ----------------------------------------------------------------------------
// bitmap_texture_sampler_top
// Affine texture sampler with clamp, repeat and mirror tiling.
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid/in_stall with in_data; func selects a texel write
//   or a span request. a write is stored in the transfer cycle, no result.
//   out channel: out_valid/out_stall with out_data, one texel per span pixel,
//   span_last set on the final one.
//   apb port: matrix, bitmap size and tile mode; write only while idle.
// sequence
//   span setup: ST_MUL steps through the shared 32x29 multiplier.
//   per pixel: ST_PIX, ST_RD and ST_WT in clamp mode; repeat and mirror mode
//   add ST_MODU and ST_MODV, each waiting on the shared remainder unit.
//   in_stall is high from the span transfer until its last pixel is loaded
//   into the output register.
// reset
//   registers return to identity matrix, 64x64 bitmap, clamp; output empty.
//   texel memory is not cleared.
// stall
//   a stalled output holds its data; the sequencer waits for the slot.
// ----------------------------------------------------------------------------
module bitmap_texture_sampler_top #(
	parameter int TEX_W_MAX = bts_pkg::TEX_W_MAX_DEF,
	parameter int TEX_H_MAX = bts_pkg::TEX_H_MAX_DEF,
	parameter int MAX_SPAN  = bts_pkg::MAX_SPAN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  bts_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output bts_pkg::out_item_t          out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bts_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import bts_pkg::*;

	localparam int DEPTH = TEX_W_MAX * TEX_H_MAX;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TMAX  = (TEX_W_MAX > TEX_H_MAX) ? TEX_W_MAX : TEX_H_MAX;
	localparam int NW    = $clog2(TMAX + 1);
	localparam int MOD_W = NW + 1;
	localparam int XW    = (TEX_W_MAX > 1) ? $clog2(TEX_W_MAX) : 1;
	localparam int YW    = (TEX_H_MAX > 1) ? $clog2(TEX_H_MAX) : 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_PIX, ST_MODU, ST_MODV, ST_RD, ST_WT
	} state_t;

	// configuration registers
	logic [31:0] mat_a_q, mat_b_q, mat_c_q, mat_d_q, mat_e_q, mat_f_q, dims_q;
	logic [1:0]  tile_q;
	logic        cfg_wr;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_a_q <= 32'd65536;
			mat_b_q <= '0;
			mat_c_q <= '0;
			mat_d_q <= '0;
			mat_e_q <= 32'd65536;
			mat_f_q <= '0;
			dims_q  <= 32'd4194368;
			tile_q  <= TILE_CLAMP;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_MAT_A: mat_a_q <= pwdata;
				REG_MAT_B: mat_b_q <= pwdata;
				REG_MAT_C: mat_c_q <= pwdata;
				REG_MAT_D: mat_d_q <= pwdata;
				REG_MAT_E: mat_e_q <= pwdata;
				REG_MAT_F: mat_f_q <= pwdata;
				REG_DIMS:  dims_q  <= pwdata;
				REG_TILE:  tile_q  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_MAT_A: prdata = mat_a_q;
			REG_MAT_B: prdata = mat_b_q;
			REG_MAT_C: prdata = mat_c_q;
			REG_MAT_D: prdata = mat_d_q;
			REG_MAT_E: prdata = mat_e_q;
			REG_MAT_F: prdata = mat_f_q;
			REG_DIMS:  prdata = dims_q;
			REG_TILE:  prdata = {30'b0, tile_q};
			default:   prdata = '0;
		endcase
	end

	// sequencer state
	state_t           state_q;
	logic [2:0]       k_q;
	logic [6:0]       left_q;
	logic [27:0]      cx_q, cy_q;
	logic [63:0]      acc_u_q, acc_v_q;
	logic signed [63:0] prod_q;
	logic [NW-1:0]    w_q, h_q;
	logic [1:0]       mode_q;
	logic             neg_q;
	logic [XW-1:0]    ix_q;
	logic [YW-1:0]    iy_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic             in_acc;
	logic             out_acc;
	logic [6:0]       cnt_sat;
	logic [DIM_W-1:0] w_raw, h_raw;
	logic [NW-1:0]    w_sat, h_sat;
	logic [31:0]      mul_x;
	logic [27:0]      mul_y;
	logic signed [63:0] prod;
	logic [31:0]      fl_u, fl_v, fl_sel;
	logic [XW-1:0]    ix_cl;
	logic [YW-1:0]    iy_cl;
	logic [NW-1:0]    n_sel;
	logic [NW-1:0]    n_start;
	logic [MOD_W-1:0] mod_m;
	logic [MOD_W-1:0] mod_m_start;
	logic [MOD_W-1:0] mod_r;
	logic [MOD_W-1:0] fix_p;
	logic [MOD_W-1:0] tiled;
	logic             mod_start;
	logic             mod_done;
	logic             tiled_mode;
	logic             load_out;
	logic             mem_we;
	logic [31:0]      widx32;
	logic [31:0]      raddr32;
	logic [31:0]      rdata;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;

	assign cnt_sat = (in_data.span_count > 7'(MAX_SPAN)) ? 7'(MAX_SPAN) : in_data.span_count;

	assign w_raw = dims_q[15:0];
	assign h_raw = dims_q[31:16];
	assign w_sat = (w_raw == '0) ? NW'(1) :
		(w_raw > DIM_W'(TEX_W_MAX)) ? NW'(TEX_W_MAX) : w_raw[NW-1:0];
	assign h_sat = (h_raw == '0) ? NW'(1) :
		(h_raw > DIM_W'(TEX_H_MAX)) ? NW'(TEX_H_MAX) : h_raw[NW-1:0];

	// shared multiplier
	always_comb begin
		case (k_q)
			3'd0:    begin mul_x = mat_a_q; mul_y = cx_q; end
			3'd1:    begin mul_x = mat_b_q; mul_y = cy_q; end
			3'd2:    begin mul_x = mat_d_q; mul_y = cx_q; end
			default: begin mul_x = mat_e_q; mul_y = cy_q; end
		endcase
	end
	assign prod = 64'($signed(mul_x) * $signed({1'b0, mul_y}));

	assign fl_u = acc_u_q[63:32];
	assign fl_v = acc_v_q[63:32];

	// clamp
	always_comb begin
		logic [31:0] nm1;
		nm1 = 32'(w_q) - 32'd1;
		if (fl_u[31])       ix_cl = '0;
		else if (fl_u > nm1) ix_cl = nm1[XW-1:0];
		else                ix_cl = fl_u[XW-1:0];
		nm1 = 32'(h_q) - 32'd1;
		if (fl_v[31])       iy_cl = '0;
		else if (fl_v > nm1) iy_cl = nm1[YW-1:0];
		else                iy_cl = fl_v[YW-1:0];
	end

	assign tiled_mode = (mode_q == TILE_REPEAT) || (mode_q == TILE_MIRROR);
	assign n_sel  = (state_q == ST_MODV) ? h_q : w_q;
	assign fl_sel = (state_q == ST_PIX) ? fl_u : fl_v;
	assign mod_m  = (mode_q == TILE_MIRROR) ? {n_sel, 1'b0} : {1'b0, n_sel};
	assign mod_start = ((state_q == ST_PIX) && tiled_mode) ||
		((state_q == ST_MODU) && mod_done);

	// modulus for the coordinate being started
	assign n_start     = (state_q == ST_PIX) ? w_q : h_q;
	assign mod_m_start = (mode_q == TILE_MIRROR) ? {n_start, 1'b0} : {1'b0, n_start};

	// fold the remainder into range
	always_comb begin
		fix_p = (neg_q && (mod_r != '0)) ? mod_m - mod_r : mod_r;
		tiled = fix_p;
		if ((mode_q == TILE_MIRROR) && (fix_p >= {1'b0, n_sel})) begin
			tiled = mod_m - MOD_W'(1) - fix_p;
		end
	end

	bts_modunit #(.MOD_W(MOD_W)) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.value   (fl_sel[31] ? 32'(-fl_sel) : fl_sel),
		.modulus (mod_m_start),
		.done    (mod_done),
		.rem     (mod_r)
	);

	assign widx32  = 32'(in_data.texel_index);
	assign mem_we  = in_acc && (in_data.func == FUNC_WRITE) && (widx32 < 32'(DEPTH));
	assign raddr32 = 32'(iy_q) * 32'(TEX_W_MAX) + 32'(ix_q);

	bts_texmem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (widx32[AW-1:0]),
		.wdata (in_data.texel_value),
		.re    (state_q == ST_RD),
		.raddr (raddr32[AW-1:0]),
		.rdata (rdata)
	);

	assign load_out = (state_q == ST_WT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_data.func == FUNC_SPAN) && (cnt_sat != '0)) begin
						state_q <= ST_MUL;
						k_q     <= '0;
						left_q  <= cnt_sat;
					end
				end
				ST_MUL: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd4) begin
						state_q <= ST_PIX;
					end
				end
				ST_PIX: begin
					state_q <= tiled_mode ? ST_MODU : ST_RD;
				end
				ST_MODU: begin
					if (mod_done) begin
						state_q <= ST_MODV;
					end
				end
				ST_MODV: begin
					if (mod_done) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_WT;
				end
				ST_WT: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						left_q      <= left_q - 7'd1;
						state_q     <= (left_q == 7'd1) ? ST_IDLE : ST_PIX;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cx_q   <= {in_data.dest_x, 1'b1, 15'b0};
			cy_q   <= {in_data.dest_y, 1'b1, 15'b0};
			w_q    <= w_sat;
			h_q    <= h_sat;
			mode_q <= tile_q;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod;
			unique case (k_q)
				3'd0: begin
					acc_u_q <= {{16{mat_c_q[31]}}, mat_c_q, 16'b0};
					acc_v_q <= {{16{mat_f_q[31]}}, mat_f_q, 16'b0};
				end
				3'd1, 3'd2: acc_u_q <= acc_u_q + prod_q;
				default:    acc_v_q <= acc_v_q + prod_q;
			endcase
		end
		if (state_q == ST_PIX) begin
			ix_q <= ix_cl;
			iy_q <= iy_cl;
		end
		if (mod_start) begin
			neg_q <= fl_sel[31];
		end
		if (mod_done && (state_q == ST_MODU)) begin
			ix_q <= tiled[XW-1:0];
		end
		if (mod_done && (state_q == ST_MODV)) begin
			iy_q <= tiled[YW-1:0];
		end
		if (load_out) begin
			out_q.texel_out <= rdata;
			out_q.span_last <= (left_q == 7'd1);
			acc_u_q <= acc_u_q + {{16{mat_a_q[31]}}, mat_a_q, 16'b0};
			acc_v_q <= acc_v_q + {{16{mat_d_q[31]}}, mat_d_q, 16'b0};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_mod_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> (state_q == ST_MODU || state_q == ST_MODV))
		else $error("remainder done outside coordinate fold");
	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten");
	a_last_ends_span: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && left_q == 7'd1) |=> (state_q == ST_IDLE && out_q.span_last))
		else $error("span end mismatch");
`endif
endmodule

[tb/bts_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bts_checker
// Watches the config port and both channels of the texture sampler, keeps
// its own copy of the matrix, bitmap size, tile mode and texel memory, works
// out the texels each span must return and compares every output transfer.
// ----------------------------------------------------------------------------
module bts_checker
	import bts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  in_item_t            in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  out_item_t           out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	output int                  fail_count,
	output int                  pending
);

	localparam int ROW = TEX_W_MAX_DEF;

	logic signed [31:0] m_a, m_b, m_c, m_d, m_e, m_f;
	logic [31:0] dims;
	logic [1:0]  tmode;
	logic [31:0] texel_mem [0:TEX_W_MAX_DEF*TEX_H_MAX_DEF-1];
	out_item_t   texel_queue[$];

	function automatic longint clip_dim(logic [15:0] raw, longint maxv);
		longint n;
		n = raw;
		if (n < 1) n = 1;
		if (n > maxv) n = maxv;
		return n;
	endfunction

	function automatic longint wrap_mod(longint c, longint n);
		longint r;
		r = c % n;
		if (r < 0) r = r + n;
		return r;
	endfunction

	function automatic longint fold_coord(longint c, longint n);
		longint m;
		case (tmode)
			TILE_REPEAT: return wrap_mod(c, n);
			TILE_MIRROR: begin
				m = wrap_mod(c, 2 * n);
				return (m >= n) ? (2 * n - 1 - m) : m;
			end
			default: begin
				if (c < 0) return 0;
				if (c > n - 1) return n - 1;
				return c;
			end
		endcase
	endfunction

	task automatic shade_span(in_item_t it);
		longint a, d, u, v, w, h, cx, cy, ix, iy;
		int n;
		out_item_t r;
		n = (it.span_count > MAX_SPAN_DEF) ? MAX_SPAN_DEF : it.span_count;
		w = clip_dim(dims[15:0], TEX_W_MAX_DEF);
		h = clip_dim(dims[31:16], TEX_H_MAX_DEF);
		cx = longint'(it.dest_x) * 65536 + 32768;
		cy = longint'(it.dest_y) * 65536 + 32768;
		a = longint'(m_a);
		d = longint'(m_d);
		u = a * cx + longint'(m_b) * cy + longint'(m_c) * 65536;
		v = d * cx + longint'(m_e) * cy + longint'(m_f) * 65536;
		for (int i = 0; i < n; i++) begin
			ix = fold_coord(u >>> 32, w);
			iy = fold_coord(v >>> 32, h);
			r.texel_out = texel_mem[iy * ROW + ix];
			r.span_last = (i == n - 1);
			texel_queue.push_back(r);
			u = u + a * 65536;
			v = v + d * 65536;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_item;
		if (!arst_n) begin
			m_a = 32'sd65536;
			m_b = '0;
			m_c = '0;
			m_d = '0;
			m_e = 32'sd65536;
			m_f = '0;
			dims = 32'd4194368;
			tmode = TILE_CLAMP;
			fail_count = 0;
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_MAT_A: m_a = pwdata;
					REG_MAT_B: m_b = pwdata;
					REG_MAT_C: m_c = pwdata;
					REG_MAT_D: m_d = pwdata;
					REG_MAT_E: m_e = pwdata;
					REG_MAT_F: m_f = pwdata;
					REG_DIMS:  dims = pwdata;
					REG_TILE:  tmode = pwdata[1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (texel_queue.size() == 0) begin
					$display("%0t: unexpected transfer, actual texel %h last %b",
						$time, out_data.texel_out, out_data.span_last);
					fail_count++;
				end else begin
					exp_item = texel_queue.pop_front();
					if (exp_item.texel_out !== out_data.texel_out) begin
						$display("%0t: texel_out expected %h actual %h",
							$time, exp_item.texel_out, out_data.texel_out);
						fail_count++;
					end
					if (exp_item.span_last !== out_data.span_last) begin
						$display("%0t: span_last expected %b actual %b",
							$time, exp_item.span_last, out_data.span_last);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (in_data.func == FUNC_WRITE)
					texel_mem[in_data.texel_index] = in_data.texel_value;
				else
					shade_span(in_data);
			end
			pending = texel_queue.size();
		end
	end

endmodule

[tb/tb_bitmap_texture_sampler_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_texture_sampler_top
// Stimulus for the texture sampler: a series of register settings covering
// every tile mode and the size extremes, each filling the visible bitmap
// before directed and random spans and texel writes, with random gaps and
// output stalls. The checker module does the predicting and comparing.
// ----------------------------------------------------------------------------
module tb_bitmap_texture_sampler_top;
	import bts_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	in_item_t           in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_item_t          out_data;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	int                 fail_count;
	int                 pending;

	bit                 quiet = 1'b0;
	int                 stall_left = 0;
	bit                 written [0:4095];
	int                 vis_w, vis_h;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	bitmap_texture_sampler_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	bts_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk or negedge arst_n) begin
		int r;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (quiet || r < 60) begin
				out_stall <= 1'b0;
				stall_left = quiet ? 0 : $urandom_range(0, 6);
			end else if (r < 95) begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(0, 3);
			end else begin
				out_stall <= 1'b1;
				stall_left = $urandom_range(20, 60);
			end
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(in_item_t it);
		int g;
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic write_texel(logic [11:0] idx, logic [31:0] val);
		in_item_t it;
		it = $bits(in_item_t)'({$urandom, $urandom, $urandom});
		it.func = FUNC_WRITE;
		it.texel_index = idx;
		it.texel_value = val;
		written[idx] = 1'b1;
		send_item(it);
	endtask

	task automatic shade(logic [11:0] x, logic [11:0] y, logic [6:0] n);
		in_item_t it;
		it = $bits(in_item_t)'({$urandom, $urandom, $urandom});
		it.func = FUNC_SPAN;
		it.dest_x = x;
		it.dest_y = y;
		it.span_count = n;
		send_item(it);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_fix();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
		if (r < 70) return $urandom;
		if (r < 80) return 32'h7FFF_FFFF;
		if (r < 90) return 32'h8000_0000;
		return '0;
	endfunction

	task automatic setup(logic [1:0] mode, logic [15:0] w_raw, logic [15:0] h_raw,
			bit ident);
		drain();
		reg_write(REG_MAT_A, ident ? 32'd65536 : rand_fix());
		reg_write(REG_MAT_B, ident ? 32'd0 : rand_fix());
		reg_write(REG_MAT_C, ident ? 32'd0 : rand_fix());
		reg_write(REG_MAT_D, ident ? 32'd0 : rand_fix());
		reg_write(REG_MAT_E, ident ? 32'd65536 : rand_fix());
		reg_write(REG_MAT_F, ident ? 32'd0 : rand_fix());
		reg_write(REG_DIMS, {h_raw, w_raw});
		reg_write(REG_TILE, {30'd0, mode});
		vis_w = (w_raw == 0) ? 1 : (w_raw > 64) ? 64 : w_raw;
		vis_h = (h_raw == 0) ? 1 : (h_raw > 64) ? 64 : h_raw;
		// every texel a span can reach must hold written data
		for (int y = 0; y < vis_h; y++)
			for (int x = 0; x < vis_w; x++)
				if (!written[y * 64 + x]) write_texel(12'(y * 64 + x), $urandom);
	endtask

	task automatic random_items(int count);
		int r;
		logic [6:0] n;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 25) begin
				if ($urandom_range(0, 2) == 0)
					write_texel(12'($urandom), $urandom);
				else
					write_texel(12'($urandom_range(0, vis_h - 1) * 64 +
						$urandom_range(0, vis_w - 1)), $urandom);
			end else begin
				n = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 12));
				shade(($urandom_range(0, 4) == 0) ? 12'hFFF : 12'($urandom),
					($urandom_range(0, 4) == 0) ? 12'h000 : 12'($urandom), n);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		setup(TILE_CLAMP, 16'd4, 16'd4, 1'b1);
		quiet = 1'b1;
		shade(12'd0, 12'd0, 7'd1);
		shade(12'd1, 12'd1, 7'd4);
		shade(12'hFFF, 12'hFFF, 7'd64);
		shade(12'd0, 12'hFFF, 7'd5);
		shade(12'hFFF, 12'd0, 7'd5);
		shade(12'd2, 12'd3, 7'd0);
		shade(12'd0, 12'd2, 7'd127);
		write_texel(12'd0, 32'h0000_0000);
		write_texel(12'd65, 32'hFFFF_FFFF);
		write_texel(12'hFFF, 32'hA5A5_5A5A);
		shade(12'd0, 12'd0, 7'd3);
		shade(12'd0, 12'd1, 7'd2);
		quiet = 1'b0;
		random_items(10);

		setup(TILE_REPEAT, 16'd8, 16'd8, 1'b0);
		random_items(15);
		setup(TILE_MIRROR, 16'd5, 16'd3, 1'b0);
		random_items(15);
		setup(2'd3, 16'd0, 16'd0, 1'b0);
		random_items(10);
		setup(TILE_MIRROR, 16'd64, 16'd1, 1'b0);
		random_items(15);
		setup(TILE_REPEAT, 16'hFFFF, 16'd0, 1'b0);
		random_items(15);
		setup(TILE_CLAMP, 16'd1, 16'hFFFF, 1'b0);
		random_items(15);
		quiet = 1'b1;
		setup(TILE_MIRROR, 16'd12, 16'd12, 1'b0);
		random_items(15);
		quiet = 1'b0;
		setup(TILE_REPEAT, 16'd7, 16'd9, 1'b0);
		random_items(15);
		setup(2'($urandom_range(0, 3)), 16'($urandom_range(1, 10)),
			16'($urandom_range(1, 10)), 1'b0);
		random_items(15);

		drain();
		if (fail_count == 0)
			$display("PASS bitmap_texture_sampler_top");
		else
			$display("FAIL bitmap_texture_sampler_top");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("FAIL bitmap_texture_sampler_top");
		$finish;
	end

endmodule
